### sv/c2d_pkg.sv
// ----------------------------------------------------------------------------
// c2d_pkg
// Shared constants, beat types and state codes for the multi-filter
// convolution block.
// ----------------------------------------------------------------------------
package c2d_pkg;

   localparam int MAX_IMAGE   = 64;
   localparam int MAX_KERNEL  = 5;
   localparam int MAX_FILTERS = 8;
   localparam int TAPS        = MAX_KERNEL * MAX_KERNEL;

   localparam int SAMPLE_W = 16;
   localparam int ACC_W    = 40;
   localparam int COL_W    = 6;
   localparam int SIDE_W   = 7;
   localparam int KSIDE_W  = 3;
   localparam int NF_W     = 4;
   localparam int FID_W    = 3;
   localparam int TAP_W    = 5;
   localparam int SLOT_W   = 3;
   localparam int ACT_W    = 15;
   localparam int LS_DEPTH = MAX_KERNEL * MAX_IMAGE;
   localparam int LS_AW    = $clog2(LS_DEPTH);

   localparam logic [1:0] KIND_PIXEL  = 2'd0;
   localparam logic [1:0] KIND_WEIGHT = 2'd1;
   localparam logic [1:0] KIND_BIAS   = 2'd2;

   localparam logic [1:0] REG_IMAGE_SIDE  = 2'd0;
   localparam logic [1:0] REG_KERNEL_SIDE = 2'd1;
   localparam logic [1:0] REG_FILTERS     = 2'd2;

   localparam logic [SIDE_W-1:0]  IMAGE_SIDE_RST  = 7'd28;
   localparam logic [KSIDE_W-1:0] KERNEL_SIDE_RST = 3'd3;
   localparam logic [NF_W-1:0]    FILTERS_RST     = 4'd8;

   typedef struct packed {
      logic [1:0]                 kind;
      logic signed [SAMPLE_W-1:0] sample;
      logic signed [SAMPLE_W-1:0] coefficient;
      logic [FID_W-1:0]           filter_sel;
      logic [TAP_W-1:0]           tap_sel;
   } req_type;

   typedef struct packed {
      logic [FID_W-1:0] filter_id;
      logic [COL_W-1:0] out_row;
      logic [COL_W-1:0] out_col;
      logic [ACT_W-1:0] activation;
      logic             last_filter;
      logic             frame_done;
   } rsp_type;

   // sample walking down the cell row
   typedef struct packed {
      logic                       valid;
      logic                       first;
      logic                       last;
      logic [TAP_W-1:0]           tap;
      logic signed [SAMPLE_W-1:0] sample;
   } chain_type;

   // coefficient load for one cell
   typedef struct packed {
      logic                       wen;
      logic                       ben;
      logic [TAP_W-1:0]           tap;
      logic signed [SAMPLE_W-1:0] data;
   } cell_load_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FEED,
      ST_WAIT,
      ST_DRAIN
   } state_type;

endpackage

### sv/conv2d_multi_filter_relu.sv
// ----------------------------------------------------------------------------
// conv2d_multi_filter_relu
// Streaming valid-mode 2-D convolution, up to eight filters, bias and ReLU.
// ----------------------------------------------------------------------------
// Pixels come in raster order on the req channel (kind 0); weight and bias
// loads (kinds 1 and 2) fill each filter cell's own stores and do not stall
// req, nor does a pixel that does not close a window. A pixel that closes a
// window starts a sweep over the k*k window taps read through the single
// line memory read port, one tap per cycle; each tap sample walks down a row
// of MAX_FILTERS filter cells, each cell registering it on to the next,
// multiplying it by its own weight and accumulating. After the last tap
// leaves the last cell the results are sent one beat per filter, filter 0
// first, through a rsp output register, held up while rsp is stalled.
// req_stall is high from the start of the sweep until the last filter's
// beat enters the rsp register.
// Rounding is half up from Q18.22 to Q7.8, saturated, negative gives zero.
// A write to any of the three registers restarts the frame at row 0, column 0.
// ----------------------------------------------------------------------------
module conv2d_multi_filter_relu
   import c2d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input beats
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   // result beats
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // ---------------- register file ----------------
   logic [SIDE_W-1:0]  image_side_ff;
   logic [KSIDE_W-1:0] kernel_side_ff;
   logic [NF_W-1:0]    filters_ff;
   logic               cfg_wr;
   logic [1:0]         cfg_idx;
   logic               cfg_hit;

   assign pready  = 1'b1;
   assign cfg_idx = paddr[3:2];
   assign cfg_wr  = psel & penable & pwrite;
   assign cfg_hit = cfg_wr & (cfg_idx == REG_IMAGE_SIDE || cfg_idx == REG_KERNEL_SIDE ||
                              cfg_idx == REG_FILTERS);

   always_ff @(posedge clock) begin
      if (reset) begin
         image_side_ff  <= IMAGE_SIDE_RST;
         kernel_side_ff <= KERNEL_SIDE_RST;
         filters_ff     <= FILTERS_RST;
      end else if (cfg_wr) begin
         unique case (cfg_idx)
            REG_IMAGE_SIDE:  image_side_ff  <= pwdata[SIDE_W-1:0];
            REG_KERNEL_SIDE: kernel_side_ff <= pwdata[KSIDE_W-1:0];
            REG_FILTERS:     filters_ff     <= pwdata[NF_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_idx)
         REG_IMAGE_SIDE:  prdata = 32'(image_side_ff);
         REG_KERNEL_SIDE: prdata = 32'(kernel_side_ff);
         REG_FILTERS:     prdata = 32'(filters_ff);
         default:         prdata = '0;
      endcase
   end

   // effective sizes: zero acts as one, oversize clamps to the maximum
   logic [SIDE_W-1:0]  side_eff;
   logic [KSIDE_W-1:0] k_eff;
   logic [NF_W-1:0]    nf_eff;

   always_comb begin
      if (image_side_ff == '0)                      side_eff = SIDE_W'(1);
      else if (image_side_ff > SIDE_W'(MAX_IMAGE))  side_eff = SIDE_W'(MAX_IMAGE);
      else                                          side_eff = image_side_ff;
      if (kernel_side_ff == '0)                     k_eff = KSIDE_W'(1);
      else if (kernel_side_ff > KSIDE_W'(MAX_KERNEL)) k_eff = KSIDE_W'(MAX_KERNEL);
      else                                          k_eff = kernel_side_ff;
      if (filters_ff == '0)                         nf_eff = NF_W'(1);
      else if (filters_ff > NF_W'(MAX_FILTERS))     nf_eff = NF_W'(MAX_FILTERS);
      else                                          nf_eff = filters_ff;
   end

   // ---------------- control ----------------
   state_type          state_ff, state_in;
   logic [COL_W-1:0]   row_ff, row_in, col_ff, col_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;      // row_ff modulo MAX_KERNEL
   logic [COL_W-1:0]   r0_ff, r0_in, c0_ff, c0_in;
   logic               final_ff, final_in;
   logic [SLOT_W-1:0]  rslot_ff, rslot_in;
   logic [KSIDE_W-1:0] ki_ff, ki_in, kj_ff, kj_in;
   logic [TAP_W-1:0]   tap_ff, tap_in;
   logic [FID_W-1:0]   fid_ff, fid_in;
   logic               iss_valid_ff, iss_valid_in;
   logic               iss_first_ff, iss_first_in;
   logic               iss_last_ff, iss_last_in;
   logic [TAP_W-1:0]   iss_tap_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               req_acc;
   logic               pix_acc;
   logic [SIDE_W-1:0]  row_p1, col_p1;
   logic               window;
   logic [KSIDE_W-1:0] km1;
   logic [SLOT_W:0]    slot_base;
   logic [LS_AW-1:0]   wr_addr, rd_addr;
   logic signed [SAMPLE_W-1:0] rd_sample;
   logic               rsp_free;
   logic               last_f;
   logic               chain_done;

   // cell row
   chain_type                  chain_w [MAX_FILTERS+1];
   cell_load_type              load_w  [MAX_FILTERS];
   logic signed [ACC_W-1:0]    acc_w   [MAX_FILTERS];
   logic signed [SAMPLE_W-1:0] bias_w  [MAX_FILTERS];
   logic [MAX_FILTERS-1:0]     done_w;

   // result arithmetic
   logic signed [ACC_W-1:0] acc_sel;
   logic signed [ACC_W-1:0] total;
   logic [ACT_W-1:0]        act;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid & ~req_stall;
   assign pix_acc   = req_acc & (req_data.kind == KIND_PIXEL);
   assign row_p1    = SIDE_W'(row_ff) + SIDE_W'(1);
   assign col_p1    = SIDE_W'(col_ff) + SIDE_W'(1);
   assign window    = (SIDE_W'(k_eff) <= side_eff) && (row_p1 >= SIDE_W'(k_eff)) &&
                      (col_p1 >= SIDE_W'(k_eff));
   assign km1       = k_eff - KSIDE_W'(1);
   assign slot_base = (slot_ff >= km1) ? (SLOT_W+1)'(slot_ff - km1)
                                       : (SLOT_W+1)'(slot_ff) + (SLOT_W+1)'(MAX_KERNEL)
                                         - (SLOT_W+1)'(km1);
   assign rsp_free  = ~rsp_valid_ff | ~rsp_stall;
   assign last_f    = ((NF_W'(fid_ff) + NF_W'(1)) == nf_eff);
   assign chain_done = done_w[MAX_FILTERS-1];

   assign wr_addr = LS_AW'(slot_ff) * LS_AW'(MAX_IMAGE) + LS_AW'(col_ff);
   assign rd_addr = LS_AW'(rslot_ff) * LS_AW'(MAX_IMAGE) + LS_AW'(c0_ff) + LS_AW'(kj_ff);

   // Q18.22 sum plus bias and the half-LSB rounding constant in one add
   assign acc_sel = acc_w[fid_ff];
   assign total   = acc_sel + ACC_W'($signed({bias_w[fid_ff], 14'h2000}));

   always_comb begin
      if (total < 0)                    act = '0;
      else if (|total[ACC_W-1:29])      act = '1;
      else                              act = total[28:14];
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      slot_in      = slot_ff;
      r0_in        = r0_ff;
      c0_in        = c0_ff;
      final_in     = final_ff;
      rslot_in     = rslot_ff;
      ki_in        = ki_ff;
      kj_in        = kj_ff;
      tap_in       = tap_ff;
      fid_in       = fid_ff;
      iss_valid_in = 1'b0;
      iss_first_in = 1'b0;
      iss_last_in  = 1'b0;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (pix_acc) begin
               // raster counters
               if (col_p1 >= side_eff) begin
                  col_in = '0;
                  if (row_p1 >= side_eff) begin
                     row_in  = '0;
                     slot_in = '0;
                  end else begin
                     row_in  = row_ff + COL_W'(1);
                     slot_in = (slot_ff == SLOT_W'(MAX_KERNEL - 1)) ? '0
                                                                  : slot_ff + SLOT_W'(1);
                  end
               end else begin
                  col_in = col_ff + COL_W'(1);
               end
               if (window) begin
                  state_in = ST_FEED;
                  r0_in    = COL_W'(row_p1 - SIDE_W'(k_eff));
                  c0_in    = COL_W'(col_p1 - SIDE_W'(k_eff));
                  final_in = (row_p1 == side_eff) && (col_p1 == side_eff);
                  rslot_in = slot_base[SLOT_W-1:0];
                  ki_in    = '0;
                  kj_in    = '0;
                  tap_in   = '0;
               end
            end
         end
         ST_FEED: begin
            // one window tap per cycle out of the line memory
            iss_valid_in = 1'b1;
            iss_first_in = (tap_ff == '0);
            iss_last_in  = (ki_ff == km1) && (kj_ff == km1);
            tap_in       = tap_ff + TAP_W'(1);
            if (kj_ff == km1) begin
               kj_in    = '0;
               ki_in    = ki_ff + KSIDE_W'(1);
               rslot_in = (rslot_ff == SLOT_W'(MAX_KERNEL - 1)) ? '0 : rslot_ff + SLOT_W'(1);
               if (ki_ff == km1) begin
                  state_in = ST_WAIT;
               end
            end else begin
               kj_in = kj_ff + KSIDE_W'(1);
            end
         end
         ST_WAIT: begin
            if (chain_done) begin
               state_in = ST_DRAIN;
               fid_in   = '0;
            end
         end
         ST_DRAIN: begin
            if (rsp_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.filter_id   = fid_ff;
               rsp_in.out_row     = r0_ff;
               rsp_in.out_col     = c0_ff;
               rsp_in.activation  = act;
               rsp_in.last_filter = last_f;
               rsp_in.frame_done  = last_f & final_ff;
               fid_in             = fid_ff + FID_W'(1);
               if (last_f) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // a write to one of the three registers starts a new frame
      if (cfg_hit) begin
         row_in  = '0;
         col_in  = '0;
         slot_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         slot_ff      <= '0;
         iss_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         slot_ff      <= slot_in;
         iss_valid_ff <= iss_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r0_ff        <= r0_in;
      c0_ff        <= c0_in;
      final_ff     <= final_in;
      rslot_ff     <= rslot_in;
      ki_ff        <= ki_in;
      kj_ff        <= kj_in;
      tap_ff       <= tap_in;
      fid_ff       <= fid_in;
      iss_first_ff <= iss_first_in;
      iss_last_ff  <= iss_last_in;
      iss_tap_ff   <= tap_ff;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------- line memory ----------------
   c2d_line_store u_line_store (
      .clock   (clock),
      .wr_en   (pix_acc),
      .wr_addr (wr_addr),
      .wr_data (req_data.sample),
      .rd_addr (rd_addr),
      .rd_data (rd_sample)
   );

   // ---------------- filter cell row ----------------
   assign chain_w[0] = '{valid:  iss_valid_ff,
                         first:  iss_first_ff,
                         last:   iss_last_ff,
                         tap:    iss_tap_ff,
                         sample: rd_sample};

   for (genvar i = 0; i < MAX_FILTERS; i++) begin : g_cell
      assign load_w[i] = '{wen:  req_acc && (req_data.kind == KIND_WEIGHT) &&
                                 (req_data.filter_sel == FID_W'(i)) &&
                                 (req_data.tap_sel < TAP_W'(TAPS)),
                           ben:  req_acc && (req_data.kind == KIND_BIAS) &&
                                 (req_data.filter_sel == FID_W'(i)),
                           tap:  req_data.tap_sel,
                           data: req_data.coefficient};

      c2d_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .chain_in  (chain_w[i]),
         .chain_out (chain_w[i+1]),
         .load      (load_w[i]),
         .acc_out   (acc_w[i]),
         .bias_out  (bias_w[i]),
         .done_out  (done_w[i])
      );
   end

endmodule

### sv/c2d_line_store.sv
// ----------------------------------------------------------------------------
// c2d_line_store
// Line memory holding the most recent kernel rows, one write and one
// registered read port.
// ----------------------------------------------------------------------------
module c2d_line_store
   import c2d_pkg::*;
(
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [LS_AW-1:0]           wr_addr,
   input  logic signed [SAMPLE_W-1:0] wr_data,
   input  logic [LS_AW-1:0]           rd_addr,
   output logic signed [SAMPLE_W-1:0] rd_data
);

   logic signed [SAMPLE_W-1:0] mem [LS_DEPTH];
   logic signed [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/c2d_cell.sv
// ----------------------------------------------------------------------------
// c2d_cell
// One filter cell: own weights and bias, multiply-accumulate over the
// window taps, forwards each sample to the next cell out of its chain register.
// ----------------------------------------------------------------------------
module c2d_cell
   import c2d_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  chain_type                  chain_in,
   output chain_type                  chain_out,
   input  cell_load_type              load,
   output logic signed [ACC_W-1:0]    acc_out,
   output logic signed [SAMPLE_W-1:0] bias_out,
   output logic                       done_out
);

   logic signed [SAMPLE_W-1:0]   wmem [TAPS];
   logic signed [SAMPLE_W-1:0]   bias_ff;
   chain_type                    chain_ff;
   logic signed [SAMPLE_W-1:0]   w_ff;
   logic signed [2*SAMPLE_W-1:0] prod_ff;
   logic                         p_valid_ff;
   logic                         p_first_ff;
   logic                         p_last_ff;
   logic signed [ACC_W-1:0]      acc_ff;
   logic                         done_ff;

   always_ff @(posedge clock) begin
      if (load.wen) begin
         wmem[load.tap] <= load.data;
      end
      if (load.ben) begin
         bias_ff <= load.data;
      end
      w_ff <= wmem[chain_in.tap];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff   <= '0;
         p_valid_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         chain_ff   <= chain_in;
         p_valid_ff <= chain_ff.valid;
         done_ff    <= p_valid_ff & p_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= chain_ff.sample * w_ff;
      p_first_ff <= chain_ff.first;
      p_last_ff  <= chain_ff.last;
      if (p_valid_ff) begin
         acc_ff <= (p_first_ff ? '0 : acc_ff) + ACC_W'(prod_ff);
      end
   end

   assign chain_out = chain_ff;
   assign acc_out   = acc_ff;
   assign bias_out  = bias_ff;
   assign done_out  = done_ff;

endmodule

### sv/c2d_checker.sv
// ----------------------------------------------------------------------------
// c2d_checker
// Port-level checks for the convolution block, bound to the top level.
// ----------------------------------------------------------------------------
module c2d_checker
   import c2d_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat dropped or changed while stalled");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_done |-> rsp_data.last_filter)
      else $error("frame_done without last_filter");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

   a_filter_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_filter |=>
         rsp_valid && rsp_data.filter_id == $past(rsp_data.filter_id) + 3'd1)
      else $error("filter results of a position not back to back in order");

endmodule

bind conv2d_multi_filter_relu c2d_checker u_c2d_checker (.*);
